// ===== hdl/lbg_pkg.sv =====
// Shared types, constants and the bond slot table of the lattice bond generator.
`default_nettype none
package lbg_pkg;

  localparam int unsigned MaxXDefault = 256;
  localparam int unsigned MaxYDefault = 256;
  localparam int unsigned QDepth      = 4;
  localparam int unsigned NumSlots    = 6;
  localparam int unsigned SlotW       = 3;
  localparam int unsigned CellW       = 17;
  localparam int unsigned SiteW       = 18;
  localparam int unsigned CoordW      = 8;
  localparam int unsigned SizeW       = 9;
  localparam int unsigned WeightW     = 32;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned InDataW     = 16;
  localparam int unsigned OutDataW    = 72;
  localparam int unsigned AddrW       = 5;
  localparam int unsigned ApbDataW    = 32;

  typedef enum logic [2:0] {
    KIND_CHAIN      = 3'd0,
    KIND_SQUARE     = 3'd1,
    KIND_TRIANGULAR = 3'd2,
    KIND_HONEYCOMB  = 3'd3,
    KIND_KAGOME     = 3'd4
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_WRAP  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_KIND   = 3'd0,
    REG_SIZE_X = 3'd1,
    REG_SIZE_Y = 3'd2,
    REG_WRAP_X = 3'd3,
    REG_WRAP_Y = 3'd4,
    REG_WEIGHT = 3'd5
  } reg_e;

  typedef enum logic [2:0] {
    NBR_SELF  = 3'd0,
    NBR_RIGHT = 3'd1,
    NBR_UP    = 3'd2,
    NBR_DIAG  = 3'd3,
    NBR_LEFT  = 3'd4
  } nbr_e;

  typedef struct packed {
    logic [2:0]               kind;
    logic [SizeW-1:0]         size_x;
    logic [SizeW-1:0]         size_y;
    logic                     wrap_x;
    logic                     wrap_y;
    logic signed [WeightW-1:0] hop_weight;
  } cfg_t;

  typedef struct packed {
    logic [CellW-1:0]    home;
    logic [CellW-1:0]    right;
    logic [CellW-1:0]    up;
    logic [CellW-1:0]    diag;
    logic [CellW-1:0]    left;
    logic [NumSlots-1:0] mask;
    status_e             status;
  } job_t;

  typedef struct packed {
    logic [1:0] scale;
    logic [1:0] a_off;
    nbr_e       nbr;
    logic [1:0] b_off;
  } slot_t;

  function automatic slot_t slot_map(input logic [2:0] kind, input logic [SlotW-1:0] slot);
    slot_t s;
    s.scale = 2'd1;
    s.a_off = 2'd0;
    s.nbr   = NBR_SELF;
    s.b_off = 2'd0;
    case (kind)
      KIND_HONEYCOMB: begin
        s.scale = 2'd2;
        case (slot)
          3'd0: s.b_off = 2'd1;
          3'd1: begin
            s.a_off = 2'd1;
            s.nbr   = NBR_RIGHT;
          end
          3'd2: begin
            s.a_off = 2'd1;
            s.nbr   = NBR_UP;
          end
          default: s.b_off = 2'd0;
        endcase
      end
      KIND_KAGOME: begin
        s.scale = 2'd3;
        case (slot)
          3'd0: s.b_off = 2'd1;
          3'd1: s.b_off = 2'd2;
          3'd2: begin
            s.a_off = 2'd1;
            s.b_off = 2'd2;
          end
          3'd3: begin
            s.a_off = 2'd1;
            s.nbr   = NBR_RIGHT;
          end
          3'd4: begin
            s.a_off = 2'd2;
            s.nbr   = NBR_UP;
          end
          3'd5: begin
            s.a_off = 2'd2;
            s.nbr   = NBR_LEFT;
            s.b_off = 2'd1;
          end
          default: s.b_off = 2'd0;
        endcase
      end
      default: begin
        case (slot)
          3'd0:    s.nbr = NBR_RIGHT;
          3'd1:    s.nbr = NBR_UP;
          3'd2:    s.nbr = NBR_DIAG;
          default: s.nbr = NBR_SELF;
        endcase
      end
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/lbg_front.sv =====
// Front end: checks a cell against the grid and builds its bond job.
`default_nettype none
module lbg_front
  import lbg_pkg::*;
#(
  parameter int unsigned MAX_X = MaxXDefault,
  parameter int unsigned MAX_Y = MaxYDefault
) (
  input  cfg_t              cfg_i,
  input  logic [CoordW-1:0] cell_x_i,
  input  logic [CoordW-1:0] cell_y_i,
  output job_t              job_o,
  output logic              keep_o
);

  logic [SizeW-1:0]  nx, ny, x9, y9;
  logic              xr, yu, xrw, yuw, is_chain, err_wrap, err_range, kind_ok;
  logic [CoordW-1:0] xn, yn, xl;
  logic [16:0]       prod0, prod1;
  logic [CellW-1:0]  row0, row1;
  logic [NumSlots-1:0] mask;

  always_comb begin
    nx = (32'(cfg_i.size_x) > MAX_X) ? SizeW'(MAX_X) : cfg_i.size_x;
    ny = (32'(cfg_i.size_y) > MAX_Y) ? SizeW'(MAX_Y) : cfg_i.size_y;
    x9 = {1'b0, cell_x_i};
    y9 = {1'b0, cell_y_i};
    xr = (x9 + 9'd1) < nx;
    yu = (y9 + 9'd1) < ny;
    xrw = xr || cfg_i.wrap_x;
    yuw = yu || cfg_i.wrap_y;
    xn = xr ? cell_x_i + 8'd1 : 8'd0;
    yn = yu ? cell_y_i + 8'd1 : 8'd0;
    xl = (cell_x_i != 8'd0) ? cell_x_i - 8'd1 : CoordW'(nx - 9'd1);
    prod0 = 17'(cell_y_i) * 17'(nx);
    prod1 = 17'(yn) * 17'(nx);
    row0 = prod0[CellW-1:0];
    row1 = prod1[CellW-1:0];

    is_chain = cfg_i.kind == KIND_CHAIN;
    kind_ok  = cfg_i.kind <= KIND_KAGOME;
    err_wrap = !is_chain && ((cfg_i.wrap_x && nx < 9'd2) || (cfg_i.wrap_y && ny < 9'd2));
    err_range = is_chain ? (cell_y_i != 8'd0 || x9 >= nx) : (x9 >= nx || y9 >= ny);

    case (cfg_i.kind)
      KIND_CHAIN:      mask = {5'b0, xr || (cfg_i.wrap_x && nx > 9'd2)};
      KIND_SQUARE:     mask = {4'b0, yuw, xrw};
      KIND_TRIANGULAR: mask = {3'b0, xrw && yuw, yuw, xrw};
      KIND_HONEYCOMB:  mask = {3'b0, yuw, xrw, 1'b1};
      KIND_KAGOME:     mask = {(cell_x_i != 8'd0 || cfg_i.wrap_x) && yuw, yuw, xrw, 3'b111};
      default:         mask = '0;
    endcase

    job_o.home  = row0 + CellW'(cell_x_i);
    job_o.right = row0 + CellW'(xn);
    job_o.up    = row1 + CellW'(cell_x_i);
    job_o.diag  = row1 + CellW'(xn);
    job_o.left  = row1 + CellW'(xl);
    if (err_wrap) begin
      job_o.mask   = 6'b000001;
      job_o.status = STATUS_WRAP;
    end else if (err_range) begin
      job_o.mask   = 6'b000001;
      job_o.status = STATUS_RANGE;
    end else begin
      job_o.mask   = mask;
      job_o.status = STATUS_OK;
    end
    keep_o = kind_ok && (job_o.mask != '0);
  end

endmodule
`default_nettype wire

// ===== hdl/lbg_queue.sv =====
// Short job queue between the front end and the bond sequencer.
`default_nettype none
module lbg_queue
  import lbg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t data_o
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  job_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = count_q == CntW'(QDepth);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== hdl/lbg_back.sv =====
// Back end: walks the head job's bonds, one per cycle if not stalled.
`default_nettype none
module lbg_back
  import lbg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                job_valid_i,
  input  job_t                job_i,
  output logic                pop_o,
  output logic                tvalid_o,
  input  logic                tready_i,
  output logic [OutDataW-1:0] tdata_o,
  output logic [StatusW-1:0]  tuser_o,
  output logic                tlast_o
);

  logic                      started_q, started_d;
  logic [NumSlots-1:0]       rem_q, rem_d, eff, pick, rest;
  logic [SlotW-1:0]          sel;
  logic                      advance, fire;
  slot_t                     sm;
  logic [CellW-1:0]          nbr_v;
  logic [SiteW-1:0]          a_v, b_v;
  logic                      out_valid_q, out_valid_d;
  logic [SiteW-1:0]          site_a_q, site_b_q;
  logic signed [WeightW-1:0] weight_q;
  status_e                   status_q;
  logic                      last_q;

  function automatic logic [SiteW-1:0] scale_cell(input logic [CellW-1:0] v,
                                                  input logic [1:0] m);
    logic [SiteW-1:0] e;
    e = SiteW'(v);
    case (m)
      2'd2:    return e << 1;
      2'd3:    return (e << 1) + e;
      default: return e;
    endcase
  endfunction

  always_comb begin
    eff  = started_q ? rem_q : job_i.mask;
    sel  = '0;
    pick = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (eff[i]) begin
        sel = SlotW'(i);
      end
    end
    pick[sel] = 1'b1;
    rest      = eff & ~pick;
    advance   = !out_valid_q || tready_i;
    fire      = job_valid_i && advance;
    pop_o     = fire && (rest == '0);
  end

  always_comb begin
    started_d   = started_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = job_valid_i;
    end
    if (fire) begin
      started_d = rest != '0;
      rem_d     = rest;
    end
  end

  always_comb begin
    sm = slot_map(cfg_i.kind, sel);
    case (sm.nbr)
      NBR_RIGHT: nbr_v = job_i.right;
      NBR_UP:    nbr_v = job_i.up;
      NBR_DIAG:  nbr_v = job_i.diag;
      NBR_LEFT:  nbr_v = job_i.left;
      default:   nbr_v = job_i.home;
    endcase
    a_v = scale_cell(job_i.home, sm.scale) + SiteW'(sm.a_off);
    b_v = scale_cell(nbr_v, sm.scale) + SiteW'(sm.b_off);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      started_q   <= started_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= job_i.status;
      last_q   <= rest == '0;
      if (job_i.status == STATUS_OK) begin
        site_a_q <= a_v;
        site_b_q <= b_v;
        weight_q <= cfg_i.hop_weight;
      end else begin
        site_a_q <= '0;
        site_b_q <= '0;
        weight_q <= '0;
      end
    end
  end

  assign tvalid_o = out_valid_q;
  assign tdata_o  = {4'b0, weight_q, site_b_q, site_a_q};
  assign tuser_o  = status_q;
  assign tlast_o  = last_q;

  a_started_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> job_valid_i)
    else $error("sequencer mid-job without a queued job");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != STATUS_OK) |-> last_q)
    else $error("error result not marked last");

endmodule
`default_nettype wire

// ===== hdl/lattice_bond_generator.sv =====
// Each cell's job is registered in the job queue; cells with no bonds are dropped.
// Throughput: one result per cycle while the output is ready; one result per bond
// (at most six, kagome) from the single-result sequencer; error cells give one.
// A four-entry job queue lets input and output stall independently.
// Reset (rst_ni low, asynchronous): registers take their defaults, queue empties.
// Top level: lattice bond generator with register port, front end, queue, sequencer.
`default_nettype none
module lattice_bond_generator
  import lbg_pkg::*;
#(
  parameter int unsigned MAX_X = MaxXDefault,
  parameter int unsigned MAX_Y = MaxYDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // cell_x[7:0], cell_y[15:8]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // site_a[17:0], site_b[35:18],
                                             // edge_weight[67:36], zero[71:68]
  output logic [StatusW-1:0]  m_axis_tuser,  // status[1:0]
  output logic                m_axis_tlast
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  reg_e reg_sel;
  job_t job_new, job_head;
  logic keep, push, full, head_valid, pop;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_e'(paddr[4:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_KIND:   cfg_d.kind       = pwdata[2:0];
        REG_SIZE_X: cfg_d.size_x     = pwdata[SizeW-1:0];
        REG_SIZE_Y: cfg_d.size_y     = pwdata[SizeW-1:0];
        REG_WRAP_X: cfg_d.wrap_x     = pwdata[0];
        REG_WRAP_Y: cfg_d.wrap_y     = pwdata[0];
        REG_WEIGHT: cfg_d.hop_weight = pwdata;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_KIND:   prdata = ApbDataW'(cfg_q.kind);
      REG_SIZE_X: prdata = ApbDataW'(cfg_q.size_x);
      REG_SIZE_Y: prdata = ApbDataW'(cfg_q.size_y);
      REG_WRAP_X: prdata = ApbDataW'(cfg_q.wrap_x);
      REG_WRAP_Y: prdata = ApbDataW'(cfg_q.wrap_y);
      REG_WEIGHT: prdata = cfg_q.hop_weight;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kind       <= KIND_SQUARE;
      cfg_q.size_x     <= 9'd4;
      cfg_q.size_y     <= 9'd4;
      cfg_q.wrap_x     <= 1'b0;
      cfg_q.wrap_y     <= 1'b0;
      cfg_q.hop_weight <= 32'sd65536;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lbg_front #(
    .MAX_X(MAX_X),
    .MAX_Y(MAX_Y)
  ) u_front (
    .cfg_i   (cfg_q),
    .cell_x_i(s_axis_tdata[7:0]),
    .cell_y_i(s_axis_tdata[15:8]),
    .job_o   (job_new),
    .keep_o  (keep)
  );

  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && s_axis_tready && keep;

  lbg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_new),
    .pop_i  (pop),
    .full_o (full),
    .valid_o(head_valid),
    .data_o (job_head)
  );

  lbg_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .job_valid_i(head_valid),
    .job_i      (job_head),
    .pop_o      (pop),
    .tvalid_o   (m_axis_tvalid),
    .tready_i   (m_axis_tready),
    .tdata_o    (m_axis_tdata),
    .tuser_o    (m_axis_tuser),
    .tlast_o    (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ===== sim/tb_lattice_bond_generator.sv =====
// Testbench for the lattice bond generator: predicted bond streams under random flow control.
`timescale 1ns / 100ps
module tb_lattice_bond_generator;
  import lbg_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned PhaseItems    = 25;
  localparam int unsigned MaxReports    = 10;
  localparam logic [2:0]  SpareReg      = 3'd7;
  localparam logic [2:0]  KindSpare     = 3'd7;

  typedef struct packed {
    logic [SiteW-1:0]          site_a;
    logic [SiteW-1:0]          site_b;
    logic signed [WeightW-1:0] weight;
    status_e                   status;
    logic                      last;
  } bond_t;

  typedef enum int {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;  // cell_x[7:0], cell_y[15:8]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;       // site_a[17:0], site_b[35:18],
                                           // edge_weight[67:36], zero[71:68]
  logic [StatusW-1:0]  m_axis_tuser;       // status[1:0]
  logic                m_axis_tlast;

  cfg_t        shadow_cfg;
  bond_t       bond_q[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  rx_mode_e    rx_mode = RX_STEADY;
  logic [7:0]  rx_pattern = 8'h01;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;

  lattice_bond_generator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MaxReports) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic bond_t make_bond(input int unsigned a, input int unsigned b);
    bond_t r;
    r.site_a = SiteW'(a);
    r.site_b = SiteW'(b);
    r.weight = shadow_cfg.hop_weight;
    r.status = STATUS_OK;
    r.last   = 1'b0;
    return r;
  endfunction

  task automatic predict_bonds(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
    int unsigned nx, ny, c, xn, yn, xl;
    bit          go_r, go_u;
    status_e     fault;
    bond_t       found[$];
    bond_t       b;
    fault = STATUS_OK;
    nx = (shadow_cfg.size_x > MaxXDefault) ? MaxXDefault : shadow_cfg.size_x;
    ny = (shadow_cfg.size_y > MaxYDefault) ? MaxYDefault : shadow_cfg.size_y;
    if (shadow_cfg.kind > KIND_KAGOME) begin
      fault = STATUS_OK;
    end else if (shadow_cfg.kind == KIND_CHAIN) begin
      if (y != 0 || x >= nx) begin
        fault = STATUS_RANGE;
      end else if (x + 1 < nx) begin
        found = {found, make_bond(x, x + 1)};
      end else if (shadow_cfg.wrap_x && nx > 2) begin
        found = {found, make_bond(x, 0)};
      end
    end else if ((shadow_cfg.wrap_x && nx < 2) || (shadow_cfg.wrap_y && ny < 2)) begin
      fault = STATUS_WRAP;
    end else if (x >= nx || y >= ny) begin
      fault = STATUS_RANGE;
    end else begin
      go_r = (x + 1 < nx) || shadow_cfg.wrap_x;
      go_u = (y + 1 < ny) || shadow_cfg.wrap_y;
      xn = (x + 1 < nx) ? x + 1 : 0;
      yn = (y + 1 < ny) ? y + 1 : 0;
      xl = (x > 0) ? x - 1 : nx - 1;
      c  = y * nx + x;
      case (shadow_cfg.kind)
        KIND_SQUARE, KIND_TRIANGULAR: begin
          if (go_r) found = {found, make_bond(c, y * nx + xn)};
          if (go_u) found = {found, make_bond(c, yn * nx + x)};
          if (shadow_cfg.kind == KIND_TRIANGULAR && go_r && go_u)
            found = {found, make_bond(c, yn * nx + xn)};
        end
        KIND_HONEYCOMB: begin
          found = {found, make_bond(2 * c, 2 * c + 1)};
          if (go_r) found = {found, make_bond(2 * c + 1, 2 * (y * nx + xn))};
          if (go_u) found = {found, make_bond(2 * c + 1, 2 * (yn * nx + x))};
        end
        default: begin
          found = {found, make_bond(3 * c, 3 * c + 1)};
          found = {found, make_bond(3 * c, 3 * c + 2)};
          found = {found, make_bond(3 * c + 1, 3 * c + 2)};
          if (go_r) found = {found, make_bond(3 * c + 1, 3 * (y * nx + xn))};
          if (go_u) found = {found, make_bond(3 * c + 2, 3 * (yn * nx + x))};
          if ((x > 0 || shadow_cfg.wrap_x) && go_u)
            found = {found, make_bond(3 * c + 2, 3 * (yn * nx + xl) + 1)};
        end
      endcase
    end
    if (fault != STATUS_OK) begin
      b = make_bond(0, 0);
      b.weight = '0;
      b.status = fault;
      b.last   = 1'b1;
      bond_q = {bond_q, b};
    end
    foreach (found[i]) begin
      b = found[i];
      b.last = (i == found.size() - 1);
      bond_q = {bond_q, b};
    end
  endtask

  task automatic send_cell(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
    int unsigned pause;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_bonds(x, y);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        pause = $urandom_range(1, 9);
        s_axis_tvalid <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (bond_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [ApbDataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_KIND:   shadow_cfg.kind       = value[2:0];
      REG_SIZE_X: shadow_cfg.size_x     = value[SizeW-1:0];
      REG_SIZE_Y: shadow_cfg.size_y     = value[SizeW-1:0];
      REG_WRAP_X: shadow_cfg.wrap_x     = value[0];
      REG_WRAP_Y: shadow_cfg.wrap_y     = value[0];
      REG_WEIGHT: shadow_cfg.hop_weight = value;
      default: ;
    endcase
  endtask

  task automatic check_reg(input logic [2:0] idx);
    logic [ApbDataW-1:0] want;
    case (idx)
      REG_KIND:   want = ApbDataW'(shadow_cfg.kind);
      REG_SIZE_X: want = ApbDataW'(shadow_cfg.size_x);
      REG_SIZE_Y: want = ApbDataW'(shadow_cfg.size_y);
      REG_WRAP_X: want = ApbDataW'(shadow_cfg.wrap_x);
      REG_WRAP_Y: want = ApbDataW'(shadow_cfg.wrap_y);
      default:    want = shadow_cfg.hop_weight;
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= AddrW'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want)
      report_error($sformatf("register %0d read %h, expected %h", idx, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_all_regs();
    for (int i = REG_KIND; i <= REG_WEIGHT; i++) check_reg(3'(i));
  endtask

  task automatic set_config(input logic [2:0] kind, input logic [SizeW-1:0] sx,
                            input logic [SizeW-1:0] sy, input bit wx, input bit wy,
                            input logic [WeightW-1:0] w);
    wait_drained();
    write_reg(REG_KIND, ApbDataW'(kind));
    write_reg(REG_SIZE_X, ApbDataW'(sx));
    write_reg(REG_SIZE_Y, ApbDataW'(sy));
    write_reg(REG_WRAP_X, ApbDataW'(wx));
    write_reg(REG_WRAP_Y, ApbDataW'(wy));
    write_reg(REG_WEIGHT, w);
    check_all_regs();
  endtask

  function automatic logic [SizeW-1:0] pick_extent();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) return SizeW'($urandom_range(1, 8));
    if (r < 16) return SizeW'(MaxXDefault);
    if (r == 16) return '0;
    if (r == 17) return SizeW'($urandom_range(MaxXDefault + 1, 511));
    return SizeW'($urandom_range(9, MaxXDefault - 1));
  endfunction

  task automatic run_random_phase(input int kind_pick, input bit squeeze);
    logic [2:0]        kind;
    logic [WeightW-1:0] w;
    int unsigned       nx, ny, r;
    logic [CoordW-1:0] x, y;
    bit                chain;
    r = $urandom_range(0, 15);
    if (kind_pick >= 0) kind = 3'(kind_pick);
    else if (r < 14) kind = 3'(r % 5);
    else kind = 3'($urandom_range(5, 7));
    r = $urandom_range(0, 9);
    w = (r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7FFF_FFFF : $urandom;
    set_config(kind, pick_extent(), pick_extent(), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), w);
    gaps_on = ($urandom_range(0, 3) != 0);
    chain = (shadow_cfg.kind == KIND_CHAIN);
    nx = (shadow_cfg.size_x > MaxXDefault) ? MaxXDefault : shadow_cfg.size_x;
    ny = (shadow_cfg.size_y > MaxYDefault) ? MaxYDefault : shadow_cfg.size_y;
    for (int i = 0; i < PhaseItems; i++) begin
      if (squeeze && i == 3) hold_requests++;
      if ($urandom_range(0, 9) < 8 && nx > 0 && (chain || ny > 0)) begin
        x = CoordW'($urandom_range(0, nx - 1));
        y = chain ? '0 : CoordW'($urandom_range(0, ny - 1));
      end else begin
        x = CoordW'($urandom);
        y = (chain && $urandom_range(0, 1)) ? '0 : CoordW'($urandom);
      end
      send_cell(x, y);
    end
  endtask

  task automatic test_defaults();
    check_all_regs();
    send_cell(8'd0, 8'd0);
    send_cell(8'd3, 8'd3);
    send_cell(8'd2, 8'd1);
    send_cell(8'd4, 8'd0);
    send_cell(8'd0, 8'd4);
  endtask

  task automatic test_chain_edges();
    set_config(KIND_CHAIN, 9'd1, 9'd4, 1'b1, 1'b0, 32'h0001_8000);
    send_cell(8'd0, 8'd0);
    send_cell(8'd0, 8'd1);
    set_config(KIND_CHAIN, 9'd3, 9'd1, 1'b1, 1'b1, 32'hFFFF_0000);
    send_cell(8'd2, 8'd0);
    send_cell(8'd0, 8'd0);
    set_config(KIND_CHAIN, 9'd2, 9'd1, 1'b1, 1'b0, 32'h0000_0001);
    send_cell(8'd1, 8'd0);
  endtask

  task automatic test_extent_two_wrap();
    set_config(KIND_TRIANGULAR, 9'd2, 9'd2, 1'b1, 1'b1, 32'h8000_0000);
    send_cell(8'd0, 8'd0);
    send_cell(8'd1, 8'd1);
    set_config(KIND_HONEYCOMB, 9'd2, 9'd2, 1'b1, 1'b1, 32'h0000_0000);
    send_cell(8'd1, 8'd0);
  endtask

  task automatic test_max_extent();
    set_config(KIND_KAGOME, 9'd511, 9'd256, 1'b1, 1'b1, 32'h7FFF_FFFF);
    send_cell(8'd255, 8'd255);
    send_cell(8'd0, 8'd255);
    send_cell(8'd255, 8'd0);
    set_config(KIND_HONEYCOMB, 9'd256, 9'd300, 1'b0, 1'b0, 32'hFFFF_FFFF);
    send_cell(8'd255, 8'd255);
  endtask

  task automatic test_error_codes();
    set_config(KIND_SQUARE, 9'd1, 9'd5, 1'b1, 1'b0, 32'h0002_0000);
    send_cell(8'd0, 8'd0);
    send_cell(8'd9, 8'd9);
    set_config(KIND_TRIANGULAR, 9'd5, 9'd0, 1'b0, 1'b0, 32'h0002_0000);
    send_cell(8'd0, 8'd0);
  endtask

  task automatic test_unknown_kind();
    set_config(KindSpare, 9'd4, 9'd4, 1'b0, 1'b0, 32'h1234_5678);
    send_cell(8'd0, 8'd0);
    send_cell(8'd255, 8'd255);
    wait_drained();
    write_reg(SpareReg, 32'hDEAD_BEEF);
    write_reg(REG_KIND, ApbDataW'(KIND_SQUARE));
    check_all_regs();
    send_cell(8'd1, 8'd1);
  endtask

  task automatic test_random_configs();
    for (int p = 0; p < 13; p++) run_random_phase((p < 10) ? p % 5 : -1, 1'b0);
  endtask

  task automatic test_backpressure();
    run_random_phase(KIND_KAGOME, 1'b1);
  endtask

  always @(posedge clk_i) begin : check_results
    bond_t seen, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.site_a = m_axis_tdata[17:0];
      seen.site_b = m_axis_tdata[35:18];
      seen.weight = m_axis_tdata[67:36];
      seen.status = status_e'(m_axis_tuser);
      seen.last   = m_axis_tlast;
      if (bond_q.size() == 0) begin
        report_error($sformatf("unexpected bond a=%0d b=%0d w=%h st=%0d last=%b",
                               seen.site_a, seen.site_b, seen.weight, seen.status,
                               seen.last));
      end else begin
        want = bond_q.pop_front();
        if (seen.site_a !== want.site_a || seen.site_b !== want.site_b ||
            seen.weight !== want.weight || seen.status !== want.status ||
            seen.last !== want.last)
          report_error($sformatf(
            "bond a=%0d b=%0d w=%h st=%0d last=%b, expected a=%0d b=%0d w=%h st=%0d last=%b",
            seen.site_a, seen.site_b, seen.weight, seen.status, seen.last,
            want.site_a, want.site_b, want.weight, want.status, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HoldCycles;
    end
    if (mode_left == 0) begin
      rx_mode    = rx_mode_e'($urandom_range(RX_STEADY, RX_PATTERN));
      mode_left  = $urandom_range(20, 120);
      rx_pattern = 8'($urandom) | 8'h01;
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY: m_axis_tready <= 1'b1;
        RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
          m_axis_tready <= rx_pattern[0];
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    shadow_cfg.kind       = KIND_SQUARE;
    shadow_cfg.size_x     = SizeW'(4);
    shadow_cfg.size_y     = SizeW'(4);
    shadow_cfg.wrap_x     = 1'b0;
    shadow_cfg.wrap_y     = 1'b0;
    shadow_cfg.hop_weight = 32'h0001_0000;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_defaults();
    test_chain_edges();
    test_extent_two_wrap();
    test_max_extent();
    test_error_codes();
    test_unknown_kind();
    test_random_configs();
    test_backpressure();
    wait_drained();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== lattice_bond_generator.f =====
hdl/lbg_pkg.sv
hdl/lbg_front.sv
hdl/lbg_queue.sv
hdl/lbg_back.sv
hdl/lattice_bond_generator.sv
sim/tb_lattice_bond_generator.sv
